@@ hw/rtl/ads94_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area downscaler 9:4 package
// Shared widths, register indexes, weight tables, lane arithmetic and the
// types that travel between the front end, the event queue and the back end.
// ----------------------------------------------------------------------------
package ads94_pkg;

  // Channel and lane widths.
  localparam int PixLaneW = 8;
  localparam int HLaneW   = 12;
  localparam int VLaneW   = 15;
  localparam int Lanes    = 3;
  localparam int PixRgbW  = Lanes * PixLaneW;
  localparam int HSumW    = Lanes * HLaneW;
  localparam int VSumW    = Lanes * VLaneW;

  // Configuration port.
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;
  localparam int AcrossW  = 8;
  localparam int DimW     = 11;

  // Position counters.
  localparam int PosW  = 4;
  localparam int BandW = 10;
  localparam logic [PosW-1:0] PosLast  = 4'd8;
  localparam logic [DimW-1:0] MaxBands = 11'd1024;

  // Center tap weight of every three-tap segment.
  localparam logic [2:0] CenterW = 3'd4;

  // Final scaling: (2*S+81)/162 equals (S+40)/81, done as a reciprocal multiply.
  localparam int TW        = 16;
  localparam int RecipW    = 15;
  localparam int ProdW     = TW + RecipW;
  localparam int DivShift  = 21;
  localparam int QuotW     = ProdW - DivShift;
  localparam logic [TW-1:0]     DivBias  = 16'd40;
  localparam logic [RecipW-1:0] DivRecip = 15'd25891;
  localparam logic [QuotW-1:0]  ChanMax  = 10'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOCKS_ACROSS = 4'd0,
    REG_BLOCKS_DOWN   = 4'd1
  } cfg_reg_e;

  // Effective frame dimensions after the zero and oversize rules.
  typedef struct packed {
    logic [DimW-1:0] width_blocks;
    logic [DimW-1:0] height_bands;
  } dims_t;

  // One finished horizontal segment sum, handed from front to back.
  typedef struct packed {
    logic [HSumW-1:0] hsum;
    logic [PosW-1:0]  row;
    logic             row_end;
    logic             frame_end;
  } hevt_t;

  // Weight of the first tap of segment seg: 4, 3, 2, 1.
  function automatic logic [2:0] first_w(input logic [1:0] seg);
    logic [2:0] w;
    case (seg)
      2'd0:    w = 3'd4;
      2'd1:    w = 3'd3;
      2'd2:    w = 3'd2;
      default: w = 3'd1;
    endcase
    return w;
  endfunction

  // Weight of the last tap of segment seg: 1, 2, 3, 4.
  function automatic logic [2:0] last_w(input logic [1:0] seg);
    return {1'b0, seg} + 3'd1;
  endfunction

  // Per lane: acc + k * pix, wrapped to the horizontal lane width.
  function automatic logic [HSumW-1:0] hmac(input logic [HSumW-1:0] acc,
                                            input logic [PixRgbW-1:0] pix,
                                            input logic [2:0] k);
    logic [HSumW-1:0] res;
    for (int ln = 0; ln < Lanes; ln++) begin
      res[ln*HLaneW +: HLaneW] = acc[ln*HLaneW +: HLaneW] +
                                 HLaneW'(k) * HLaneW'(pix[ln*PixLaneW +: PixLaneW]);
    end
    return res;
  endfunction

  // Per lane: acc + k * h, wrapped to the vertical lane width.
  function automatic logic [VSumW-1:0] vmac(input logic [VSumW-1:0] acc,
                                            input logic [HSumW-1:0] h,
                                            input logic [2:0] k);
    logic [VSumW-1:0] res;
    for (int ln = 0; ln < Lanes; ln++) begin
      res[ln*VLaneW +: VLaneW] = acc[ln*VLaneW +: VLaneW] +
                                 VLaneW'(k) * VLaneW'(h[ln*HLaneW +: HLaneW]);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/ads94_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area downscaler 9:4 channel interfaces
// Valid/ready channels for source pixels, output pixels and register writes.
// ----------------------------------------------------------------------------

// Source pixel channel: 7:0 red, 15:8 green, 23:16 blue, 31:24 alpha.
interface ads94_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// Output pixel channel with row and frame markers.
interface ads94_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, output red, output green, output blue,
                  output row_end, output frame_end, input ready);
  modport sink (input valid, input red, input green, input blue,
                input row_end, input frame_end, output ready);
endinterface

// Register write channel.
interface ads94_cfg_if import ads94_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/area_downscale_nine_to_four.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area downscaler, nine to four
// Scales an RGBA raster stream to 4/9 size in both directions and drops alpha.
// ----------------------------------------------------------------------------
// Source pixels are taken at one per clock, sustained, in raster order; the
// frame is 9*blocks_across pixels wide and 9*blocks_down rows high, and every
// output pixel leaves in output raster order with row_end and frame_end
// markers. After the transfer of its last source pixel, an output pixel
// takes these steps: the front end closes a horizontal segment sum in the
// transfer cycle, a four-entry event queue decouples it from the back end,
// and the back end passes it through the line accumulator read, the
// vertical fold, the reciprocal multiply and the output register, each
// registered, in that order. The pixel input stalls only when that queue
// fills, which needs the output side to hold off. The two line accumulators
// are RAMs of 4*MAX_BLOCKS_ACROSS words of 45 bits; the first row of every
// band overwrites them, so no clearing pass follows reset. Registers: index
// 0 blocks_across, index 1 blocks_down; write them only between frames.
// ----------------------------------------------------------------------------
module area_downscale_nine_to_four import ads94_pkg::*; #(
  parameter int MAX_BLOCKS_ACROSS = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ads94_pixel_if.sink     pixel_i,
  ads94_result_if.source  result_o,
  ads94_cfg_if.sink       cfg_i
);

  localparam int LineDepth = 4 * MAX_BLOCKS_ACROSS;
  localparam int XW        = $clog2(LineDepth);
  localparam int EvtW      = XW + $bits(hevt_t);
  localparam int QDepth    = 4;

  logic [AcrossW-1:0] across_q;
  logic [DimW-1:0]    down_q;
  dims_t              dims;

  logic               push, pop, q_full, q_empty;
  logic [XW-1:0]      push_x, head_x;
  hevt_t              push_evt, head_evt;
  logic [EvtW-1:0]    head_word;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= AcrossW'(1);
      down_q   <= DimW'(1);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_BLOCKS_ACROSS) begin
        across_q <= cfg_i.data[AcrossW-1:0];
      end else if (cfg_i.index == REG_BLOCKS_DOWN) begin
        down_q <= cfg_i.data[DimW-1:0];
      end
    end
  end

  // Effective dimensions: zero acts as one, oversize is clamped.
  always_comb begin
    if (across_q == '0) begin
      dims.width_blocks = DimW'(1);
    end else if (DimW'(across_q) > DimW'(MAX_BLOCKS_ACROSS)) begin
      dims.width_blocks = DimW'(MAX_BLOCKS_ACROSS);
    end else begin
      dims.width_blocks = DimW'(across_q);
    end
    if (down_q == '0) begin
      dims.height_bands = DimW'(1);
    end else if (down_q > MaxBands) begin
      dims.height_bands = MaxBands;
    end else begin
      dims.height_bands = down_q;
    end
  end

  ads94_front #(
    .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS),
    .XW                (XW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (pixel_i),
    .dims_i   (dims),
    .q_full_i (q_full),
    .push_o   (push),
    .x_o      (push_x),
    .evt_o    (push_evt)
  );

  ads94_fifo #(
    .Width (EvtW),
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_x, push_evt}),
    .full_o  (q_full),
    .pop_i   (pop),
    .rdata_o (head_word),
    .empty_o (q_empty)
  );

  assign head_x   = head_word[EvtW-1 -: XW];
  assign head_evt = head_word[$bits(hevt_t)-1:0];

  ads94_back #(
    .XW        (XW),
    .LineDepth (LineDepth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_x_i     (head_x),
    .q_evt_i   (head_evt),
    .q_pop_o   (pop),
    .result_o  (result_o)
  );

`ifndef SYNTHESIS
  a_frame_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.frame_end) |-> result_o.row_end)
    else $error("frame end marker without row end marker");
`endif

endmodule

@@ hw/rtl/ads94_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area downscaler 9:4 simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ads94_ram #(
  parameter int Width = 45,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ads94_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area downscaler 9:4 event queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ads94_fifo #(
  parameter int Width = 51,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign rdata_o = store_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("event queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("event queue read while empty");
`endif

endmodule

@@ hw/rtl/ads94_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area downscaler 9:4 front end
// Accepts source pixels, tracks the raster position and builds the
// horizontal three-tap segment sums; each finished sum becomes a queue event.
// ----------------------------------------------------------------------------
module ads94_front import ads94_pkg::*; #(
  parameter int MAX_BLOCKS_ACROSS = 128,
  parameter int XW                = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ads94_pixel_if.sink     pixel_i,
  input  dims_t           dims_i,
  input  logic            q_full_i,
  output logic            push_o,
  output logic [XW-1:0]   x_o,
  output hevt_t           evt_o
);

  localparam int BcW = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;

  logic [PosW-1:0]    col_q, col_d;
  logic [BcW-1:0]     bc_q, bc_d;
  logic [PosW-1:0]    row_q, row_d;
  logic [BandW-1:0]   band_q, band_d;
  logic [HSumW-1:0]   cur_q, cur_d;
  logic [HSumW-1:0]   nxt_q, nxt_d;

  logic               accept;
  logic [PixRgbW-1:0] pix;
  logic [1:0]         seg;
  logic [HSumW-1:0]   hsum;
  logic               last_block;
  logic               last_band;
  logic               row_end;

  // A transfer happens whenever a pixel is valid and the event queue has room.
  assign pixel_i.ready = !q_full_i;
  assign accept        = pixel_i.valid && !q_full_i;
  assign pix           = pixel_i.pixel[PixRgbW-1:0];

  assign seg        = 2'(col_q[3:1] - 3'd1);
  assign last_block = (DimW'(bc_q) + DimW'(1)) >= dims_i.width_blocks;
  assign last_band  = (DimW'(band_q) + DimW'(1)) >= dims_i.height_bands;
  assign hsum       = hmac(cur_q, pix, last_w(seg));
  assign row_end    = (col_q == PosLast) && last_block;

  // Horizontal segment sums.
  always_comb begin
    cur_d  = cur_q;
    nxt_d  = nxt_q;
    push_o = 1'b0;
    if (accept) begin
      if (col_q == '0) begin
        cur_d = hmac('0, pix, CenterW);
      end else if (col_q == 4'd1) begin
        cur_d = hmac(cur_q, pix, CenterW);
      end else if (col_q[0] && (col_q < PosLast)) begin
        cur_d = hmac(nxt_q, pix, CenterW);
      end else if (col_q <= PosLast) begin
        cur_d  = hsum;
        push_o = 1'b1;
        if (col_q < PosLast) begin
          nxt_d = hmac('0, pix, first_w(seg + 2'd1));
        end
      end
    end
  end

  // Raster position counters.
  always_comb begin
    col_d  = col_q;
    bc_d   = bc_q;
    row_d  = row_q;
    band_d = band_q;
    if (accept) begin
      if (col_q >= PosLast) begin
        col_d = '0;
        if (last_block) begin
          bc_d = '0;
          if (row_q >= PosLast) begin
            row_d  = '0;
            band_d = last_band ? '0 : band_q + BandW'(1);
          end else begin
            row_d = row_q + PosW'(1);
          end
        end else begin
          bc_d = bc_q + BcW'(1);
        end
      end else begin
        col_d = col_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      bc_q   <= '0;
      row_q  <= '0;
      band_q <= '0;
      cur_q  <= '0;
      nxt_q  <= '0;
    end else begin
      col_q  <= col_d;
      bc_q   <= bc_d;
      row_q  <= row_d;
      band_q <= band_d;
      cur_q  <= cur_d;
      nxt_q  <= nxt_d;
    end
  end

  // Event contents: line column, segment sum, source row and output markers.
  assign x_o             = XW'({bc_q, seg});
  assign evt_o.hsum      = hsum;
  assign evt_o.row       = row_q;
  assign evt_o.row_end   = row_end;
  assign evt_o.frame_end = row_end && (row_q == PosLast) && last_band;

`ifndef SYNTHESIS
  a_push_on_even_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (col_q == 4'd2 || col_q == 4'd4 || col_q == 4'd6 || col_q == 4'd8))
    else $error("segment event outside a segment end column");
`endif

endmodule

@@ hw/rtl/ads94_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area downscaler 9:4 back end
// Folds segment events into the two line accumulators, finishes the vertical
// sums, scales them by 1/81 with rounding and holds the output pixel.
// ----------------------------------------------------------------------------
module ads94_back import ads94_pkg::*; #(
  parameter int XW        = 9,
  parameter int LineDepth = 512
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  logic [XW-1:0]   q_x_i,
  input  hevt_t           q_evt_i,
  output logic            q_pop_o,
  ads94_result_if.source  result_o
);

  logic                   adv;

  // Stage 1: line read in flight.
  logic                   s1_valid_q;
  logic [XW-1:0]          s1_x_q;
  hevt_t                  s1_evt_q;

  // Stage 2: biased vertical sums.
  logic                   s2_valid_q;
  logic [Lanes*TW-1:0]    s2_t_q;
  logic                   s2_row_end_q;
  logic                   s2_frame_end_q;

  // Stage 3: reciprocal products.
  logic                   s3_valid_q;
  logic [Lanes*ProdW-1:0] s3_prod_q;
  logic                   s3_row_end_q;
  logic                   s3_frame_end_q;

  // Output register.
  logic                   res_valid_q;
  logic [PixLaneW-1:0]    res_chan_q [Lanes];
  logic                   res_row_end_q;
  logic                   res_frame_end_q;

  logic [VSumW-1:0]       up_rd, lo_rd;
  logic [VSumW-1:0]       up_wd, lo_wd;
  logic                   up_we, lo_we, emit;
  logic [VSumW-1:0]       fin;
  logic [1:0]             m;
  logic [Lanes*TW-1:0]    t_d;
  logic [Lanes*ProdW-1:0] prod_d;
  logic [PixLaneW-1:0]    chan_d [Lanes];

  // The whole back pipeline moves when the output register can take a pixel.
  assign adv     = !res_valid_q || result_o.ready;
  assign q_pop_o = adv && !q_empty_i;

  // Line accumulators for the output row being finished and the one started.
  ads94_ram #(.Width(VSumW), .Depth(LineDepth)) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (up_we && adv),
    .waddr_i (s1_x_q),
    .wdata_i (up_wd),
    .re_i    (adv),
    .raddr_i (q_x_i),
    .rdata_o (up_rd)
  );

  ads94_ram #(.Width(VSumW), .Depth(LineDepth)) u_line_lower (
    .clk_i   (clk_i),
    .we_i    (lo_we && adv),
    .waddr_i (s1_x_q),
    .wdata_i (lo_wd),
    .re_i    (adv),
    .raddr_i (q_x_i),
    .rdata_o (lo_rd)
  );

  // Vertical fold: start, continue or finish a three-row segment.
  assign m   = 2'(s1_evt_q.row[3:1] - 3'd1);
  assign fin = vmac(up_rd, s1_evt_q.hsum, last_w(m));

  always_comb begin
    up_we = 1'b0;
    lo_we = 1'b0;
    emit  = 1'b0;
    up_wd = fin;
    lo_wd = vmac('0, s1_evt_q.hsum, first_w(m + 2'd1));
    if (s1_valid_q) begin
      if (s1_evt_q.row == '0) begin
        up_wd = vmac('0, s1_evt_q.hsum, CenterW);
        up_we = 1'b1;
      end else if (s1_evt_q.row == 4'd1) begin
        up_wd = vmac(up_rd, s1_evt_q.hsum, CenterW);
        up_we = 1'b1;
      end else if (s1_evt_q.row[0] && (s1_evt_q.row < PosLast)) begin
        up_wd = vmac(lo_rd, s1_evt_q.hsum, CenterW);
        up_we = 1'b1;
      end else if (s1_evt_q.row <= PosLast) begin
        up_we = 1'b1;
        lo_we = (s1_evt_q.row < PosLast);
        emit  = 1'b1;
      end
    end
  end

  // Rounding bias, reciprocal multiply and saturation per channel.
  always_comb begin
    for (int ln = 0; ln < Lanes; ln++) begin
      t_d[ln*TW +: TW]       = TW'(fin[ln*VLaneW +: VLaneW]) + DivBias;
      prod_d[ln*ProdW +: ProdW] = ProdW'(s2_t_q[ln*TW +: TW]) * ProdW'(DivRecip);
      chan_d[ln] = (s3_prod_q[ln*ProdW + DivShift +: QuotW] > ChanMax) ?
                   PixLaneW'(ChanMax) :
                   s3_prod_q[ln*ProdW + DivShift +: PixLaneW];
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_empty_i;
      s2_valid_q  <= emit;
      s3_valid_q  <= s2_valid_q;
      res_valid_q <= s3_valid_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q          <= q_x_i;
      s1_evt_q        <= q_evt_i;
      s2_t_q          <= t_d;
      s2_row_end_q    <= s1_evt_q.row_end;
      s2_frame_end_q  <= s1_evt_q.frame_end;
      s3_prod_q       <= prod_d;
      s3_row_end_q    <= s2_row_end_q;
      s3_frame_end_q  <= s2_frame_end_q;
      res_chan_q      <= chan_d;
      res_row_end_q   <= s3_row_end_q;
      res_frame_end_q <= s3_frame_end_q;
    end
  end

  assign result_o.valid     = res_valid_q;
  assign result_o.red       = res_chan_q[0];
  assign result_o.green     = res_chan_q[1];
  assign result_o.blue      = res_chan_q[2];
  assign result_o.row_end   = res_row_end_q;
  assign result_o.frame_end = res_frame_end_q;

`ifndef SYNTHESIS
  a_no_line_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && !q_empty_i) |-> (q_x_i != s1_x_q))
    else $error("line read and write hit the same column in one cycle");
`endif

endmodule
